// ===== rtl/auth_key_rollover_select_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the key rollover selector
// Clocked implication checks shared by the RTL that asserts.
// ---------------------------------------------------------------------------
`ifndef AUTH_KEY_ROLLOVER_SELECT_DEFINES_SVH
`define AUTH_KEY_ROLLOVER_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define AKRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define AKRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/akrs_pkg.sv =====
// ---------------------------------------------------------------------------
// Key rollover selector package
// Payload types, entry record, status and kind codes.
// ---------------------------------------------------------------------------
package akrs_pkg;

  localparam int MAX_ENTRIES     = 64;
  localparam int CNT_W           = 7;
  localparam bit KEYS_PARTIAL_OK = 1'b0;
  localparam int NAME_MAX        = 32;
  localparam int ID_MAX          = 63;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_RECV  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NAME   = 3'd1,
    ST_ENTRY  = 3'd2,
    ST_WINDOW = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_COUNT  = 2'd1,
    CFG_NAME   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         slot;
    logic [7:0]         key_id;
    logic               entry_enabled;
    logic               secret_nonzero;
    logic               secret_set;
    logic               algorithm_set;
    logic signed [63:0] begin_time;
    logic               has_end;
    logic signed [63:0] end_time;
    logic [31:0]        tolerance;
    logic signed [63:0] current_time;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_slot;
    logic [5:0] chosen_id;
    logic [2:0] table_status;
  } out_t;

  typedef struct packed {
    logic [7:0]         id;
    logic               en;
    logic               snz;
    logic               sset;
    logic               aset;
    logic               has_end;
    logic signed [63:0] bgn;
    logic signed [63:0] fin;
    logic [31:0]        tol;
  } ent_t;

endpackage

// ===== rtl/auth_key_rollover_select.sv =====
// ---------------------------------------------------------------------------
// Authentication key rollover selector
// Key table with validation scan, send selection and receive window check.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_t request
// out_    | output    | out_valid/out_stall | out_t result
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request at a time; a table scan reads one entry per cycle from the
// single read port of the entry memory, whose read data is registered.
// A write runs the validation scan over the n slots in use (max 64), a send
// query adds a send scan and a receive query a find scan and a successor
// scan; the next request is taken only once the sequencer is back in idle.
// Reset clears control state only; the entry memory holds no reset value.
// A stalled result waits in the output register; the next request is taken
// once the current one has been handed to it.
module auth_key_rollover_select
  import akrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

`include "auth_key_rollover_select_defines.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_VAL   = 8'b0000_0010,
    S_SEND  = 8'b0000_0100,
    S_RFIND = 8'b0000_1000,
    S_RCHK  = 8'b0001_0000,
    S_RNEXT = 8'b0010_0000,
    S_RFIN  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic                en_r;
  logic [CNT_W-1:0]    count_r;
  logic [7:0]          name_r;
  in_t                 req_r;
  ent_t                mem [MAX_ENTRIES];
  ent_t                rd_data_r;
  logic [5:0]          rd_addr;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [5:0]          pidx_r;
  logic [CNT_W-1:0]    n_used;
  logic                issue, scan_done;
  logic [63:0]         seen_r, seen_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                found_r, found_nxt;
  logic [5:0]          sel_r, sel_nxt;
  logic [7:0]          best_id_r, best_id_nxt;
  logic signed [63:0]  best_r, best_nxt;
  logic                have_r, have_nxt;
  logic signed [63:0]  next_r;
  logic [31:0]         tol_r;
  logic                out_valid_r;
  out_t                out_data_r;
  logic                accept, load_out;
  logic                fault_entry, fault_win, fault_dup;
  logic signed [64:0]  diff, sum;
  logic signed [63:0]  lo_sat, hi_sat;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      count_r <= '0;
      name_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE: en_r    <= cfg_data[0];
        CFG_COUNT:  count_r <= cfg_data[CNT_W-1:0];
        CFG_NAME:   name_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign n_used = (count_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count_r;

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
  end

  // Entry memory: written on an accepted write request, read once a cycle.
  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_WRITE) begin
      mem[in_data.slot] <= '{id: in_data.key_id, en: in_data.entry_enabled,
                             snz: in_data.secret_nonzero, sset: in_data.secret_set,
                             aset: in_data.algorithm_set, has_end: in_data.has_end,
                             bgn: in_data.begin_time, fin: in_data.end_time,
                             tol: in_data.tolerance};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_addr = idx_r[5:0];
  assign issue   = (idx_r < n_used);
  assign scan_done = !issue && !rd_vld_r;

  // Entry checks used by the validation scan.
  assign fault_entry = (rd_data_r.id > 8'(ID_MAX)) ||
                       (!KEYS_PARTIAL_OK && (!rd_data_r.sset || !rd_data_r.aset ||
                                             !rd_data_r.snz)) ||
                       (rd_data_r.sset && !rd_data_r.snz);
  assign fault_win   = rd_data_r.has_end && (rd_data_r.fin <= rd_data_r.bgn);
  assign fault_dup   = seen_r[rd_data_r.id[5:0]];

  // Saturating window bounds around the chosen key, using its own tolerance.
  assign diff   = {best_r[63], best_r} - $signed({33'd0, tol_r});
  assign sum    = {best_r[63], best_r} + $signed({33'd0, tol_r});
  assign lo_sat = (diff[64] != diff[63]) ? {1'b1, 63'd0} : diff[63:0];
  assign hi_sat = (sum[64] != sum[63])   ? {1'b0, {63{1'b1}}} : sum[63:0];

  // Sequencer and scan unit.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    rd_vld_nxt  = 1'b0;
    seen_nxt    = seen_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    sel_nxt     = sel_r;
    best_id_nxt = best_id_r;
    best_nxt    = best_r;
    have_nxt    = have_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_VAL;
          idx_nxt    = '0;
          seen_nxt   = '0;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          have_nxt   = 1'b0;
        end
      end
      S_VAL: begin
        idx_nxt    = idx_r + CNT_W'(issue);
        rd_vld_nxt = issue;
        if (name_r == 8'd0 || name_r > 8'(NAME_MAX)) begin
          status_nxt = ST_NAME;
          state_nxt  = S_DONE;
        end else if (rd_vld_r && (fault_entry || fault_win || fault_dup)) begin
          status_nxt = fault_entry ? ST_ENTRY : (fault_win ? ST_WINDOW : ST_DUP);
          state_nxt  = S_DONE;
        end else begin
          if (rd_vld_r) seen_nxt = seen_r | (64'd1 << rd_data_r.id[5:0]);
          if (scan_done) begin
            if (en_r && req_r.kind == KIND_SEND)      state_nxt = S_SEND;
            else if (en_r && req_r.kind == KIND_RECV) state_nxt = S_RFIND;
            else                                      state_nxt = S_DONE;
          end
        end
        if (state_nxt != S_VAL) begin
          idx_nxt    = '0;
          rd_vld_nxt = 1'b0;
        end
      end
      S_SEND: begin
        idx_nxt    = idx_r + CNT_W'(issue);
        rd_vld_nxt = issue;
        if (rd_vld_r && rd_data_r.en && rd_data_r.snz &&
            !(req_r.current_time < rd_data_r.bgn)) begin
          if (!found_r || rd_data_r.bgn > best_r ||
              (rd_data_r.bgn == best_r && rd_data_r.id > best_id_r)) begin
            found_nxt   = 1'b1;
            sel_nxt     = pidx_r;
            best_nxt    = rd_data_r.bgn;
            best_id_nxt = rd_data_r.id;
          end
        end
        if (scan_done) state_nxt = S_DONE;
      end
      S_RFIND: begin
        idx_nxt    = idx_r + CNT_W'(issue);
        rd_vld_nxt = issue;
        if (rd_vld_r && rd_data_r.id == req_r.key_id) begin
          sel_nxt     = pidx_r;
          best_nxt    = rd_data_r.bgn;
          best_id_nxt = rd_data_r.id;
          found_nxt   = rd_data_r.en && rd_data_r.snz;
          state_nxt   = S_RCHK;
          idx_nxt     = '0;
          rd_vld_nxt  = 1'b0;
        end else if (scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_RCHK: begin
        if (!found_r || req_r.current_time < lo_sat) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RNEXT;
        end
      end
      S_RNEXT: begin
        idx_nxt    = idx_r + CNT_W'(issue);
        rd_vld_nxt = issue;
        if (rd_vld_r && rd_data_r.en && rd_data_r.bgn > best_r &&
            (!have_r || rd_data_r.bgn < next_r)) begin
          have_nxt = 1'b1;
        end
        if (scan_done) state_nxt = S_RFIN;
      end
      S_RFIN: begin
        found_nxt = !have_r || (req_r.current_time < hi_sat);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Successor begin time found by the receive scan.
  always_ff @(posedge clk) begin
    if (state_r == S_RNEXT && rd_vld_r && rd_data_r.en &&
        rd_data_r.bgn > best_r && (!have_r || rd_data_r.bgn < next_r)) begin
      next_r <= rd_data_r.bgn;
    end
  end

  // The saturating add works on the successor time in the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r    <= rd_addr;
    seen_r    <= seen_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    sel_r     <= sel_nxt;
    best_id_r <= best_id_nxt;
    have_r    <= have_nxt;
    if (state_r == S_RNEXT && scan_done && have_r) best_r <= next_r;
    else best_r <= best_nxt;
    // The matched key's own tolerance sets its receive window.
    if (state_r == S_RFIND && state_nxt == S_RCHK) tol_r <= rd_data_r.tol;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.found        <= found_r;
      out_data_r.chosen_slot  <= found_r ? sel_r : 6'd0;
      out_data_r.chosen_id    <= found_r ? best_id_r[5:0] : 6'd0;
      out_data_r.table_status <= status_r;
    end
  end

  `AKRS_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE,
                    "request accepted but sequencer stayed idle")
  `AKRS_ASSERT_NOW(a_found_needs_ok, out_valid_r && out_data_r.found,
                   out_data_r.table_status == ST_OK,
                   "key selected from an invalid table")
  `AKRS_ASSERT_NOW(a_read_in_range, rd_vld_r, {1'b0, pidx_r} < n_used,
                   "entry read beyond the slots in use")

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the authentication key rollover selector
// Fills the key table, then runs phases under different register settings.
// The first phase starts with a short directed set of requests and every phase
// continues with constrained-by-hand random traffic. Expected results come from a
// behavioural predictor of the validation scan, the send selection and the
// receive window. Both handshakes idle at random outside the quiet phase.
// ---------------------------------------------------------------------------
module tb_top;
  import akrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint T_MIN = 64'sh8000_0000_0000_0000;
  localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     DRAIN = 240;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  auth_key_rollover_select dut (.*);

  // Shadow of the key table and the registers.
  logic [7:0]  key_id_tbl  [MAX_ENTRIES];
  logic        key_en      [MAX_ENTRIES];
  logic        key_snz     [MAX_ENTRIES];
  logic        key_sset    [MAX_ENTRIES];
  logic        key_aset    [MAX_ENTRIES];
  logic        key_has_end [MAX_ENTRIES];
  longint      key_begin   [MAX_ENTRIES];
  longint      key_end     [MAX_ENTRIES];
  logic [31:0] key_tol     [MAX_ENTRIES];
  logic        chain_en;
  logic [6:0]  slots_used;
  logic [7:0]  name_len;

  in_t   pending_reqs [$];
  out_t  awaited      [$];
  int    errors;
  bit    took;
  bit    quiet;
  bit    bad_slot [MAX_ENTRIES];
  logic [7:0] home_id [MAX_ENTRIES];

  function automatic int used_slots();
    return (slots_used > MAX_ENTRIES) ? MAX_ENTRIES : int'(slots_used);
  endfunction

  function automatic longint sat_minus(longint v, logic [31:0] d);
    longint sd;
    sd = longint'({32'd0, d});
    return (v < T_MIN + sd) ? T_MIN : v - sd;
  endfunction

  function automatic longint sat_plus(longint v, logic [31:0] d);
    longint sd;
    sd = longint'({32'd0, d});
    return (v > T_MAX - sd) ? T_MAX : v + sd;
  endfunction

  // Linear validation scan, stopping at the first fault.
  function automatic status_t table_check();
    logic [63:0] seen;
    seen = '0;
    if (name_len == 0 || name_len > NAME_MAX) return ST_NAME;
    for (int i = 0; i < used_slots(); i++) begin
      if (key_id_tbl[i] > ID_MAX || !key_sset[i] || !key_aset[i] || !key_snz[i])
        return ST_ENTRY;
      if (key_has_end[i] && key_end[i] <= key_begin[i]) return ST_WINDOW;
      if (seen[key_id_tbl[i][5:0]]) return ST_DUP;
      seen[key_id_tbl[i][5:0]] = 1'b1;
    end
    return ST_OK;
  endfunction

  // Receive window: begin minus tolerance up to the successor's begin plus it.
  function automatic bit window_ok(int k, longint now);
    bit     have;
    longint nxt;
    have = 0;
    nxt  = 0;
    if (!key_en[k] || !key_snz[k] || now < sat_minus(key_begin[k], key_tol[k]))
      return 0;
    for (int i = 0; i < used_slots(); i++) begin
      if (!key_en[i] || key_begin[i] <= key_begin[k]) continue;
      if (!have || key_begin[i] < nxt) begin
        nxt  = key_begin[i];
        have = 1;
      end
    end
    return !have || now < sat_plus(nxt, key_tol[k]);
  endfunction

  function automatic out_t rollover_result(in_t q);
    out_t    r;
    status_t st;
    bit      hit;
    int      sel;
    longint  now;
    int      s;
    hit = 0;
    sel = 0;
    now = q.current_time;
    if (kind_t'(q.kind) == KIND_WRITE) begin
      s = q.slot;
      key_id_tbl[s]  = q.key_id;
      key_en[s]      = q.entry_enabled;
      key_snz[s]     = q.secret_nonzero;
      key_sset[s]    = q.secret_set;
      key_aset[s]    = q.algorithm_set;
      key_has_end[s] = q.has_end;
      key_begin[s]   = q.begin_time;
      key_end[s]     = q.end_time;
      key_tol[s]     = q.tolerance;
    end
    st = table_check();
    if (chain_en && st == ST_OK) begin
      if (kind_t'(q.kind) == KIND_SEND) begin
        for (int i = 0; i < used_slots(); i++) begin
          if (!key_en[i] || !key_snz[i] || now < key_begin[i]) continue;
          if (!hit || key_begin[i] > key_begin[sel] ||
              (key_begin[i] == key_begin[sel] && key_id_tbl[i] > key_id_tbl[sel])) begin
            sel = i;
            hit = 1;
          end
        end
      end else if (kind_t'(q.kind) == KIND_RECV) begin
        for (int i = 0; i < used_slots(); i++) begin
          if (key_id_tbl[i] == q.key_id) begin
            if (window_ok(i, now)) begin
              sel = i;
              hit = 1;
            end
            break;
          end
        end
      end
    end
    r.found        = hit;
    r.chosen_slot  = hit ? 6'(sel) : '0;
    r.chosen_id    = hit ? key_id_tbl[sel][5:0] : '0;
    r.table_status = st;
    return r;
  endfunction

  // Clock and the run limit.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("auth_key_rollover_select verification failed");
    $finish;
  end

  // Request driver: a request is presented at the falling edge and held
  // until taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      awaited.push_back(rollover_result(pending_reqs.pop_front()));
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || took) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    took = 0;
  end

  // Result monitor with random back-pressure.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = awaited.pop_front();
        if (out_data.found !== e.found) begin
          $display("%0t: found exp %0d got %0d", $time, e.found, out_data.found);
          errors++;
        end
        if (out_data.chosen_slot !== e.chosen_slot) begin
          $display("%0t: chosen_slot exp %0d got %0d", $time, e.chosen_slot,
                   out_data.chosen_slot);
          errors++;
        end
        if (out_data.chosen_id !== e.chosen_id) begin
          $display("%0t: chosen_id exp %0d got %0d", $time, e.chosen_id,
                   out_data.chosen_id);
          errors++;
        end
        if (out_data.table_status !== e.table_status) begin
          $display("%0t: table_status exp %0d got %0d", $time, e.table_status,
                   out_data.table_status);
          errors++;
        end
      end
    end
  end

  // Register write; the shadow is updated at the accepting edge.
  task automatic reg_write(cfg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE: chain_en   = val[0];
      CFG_COUNT:  slots_used = val[6:0];
      default:    name_len   = val;
    endcase
  endtask

  task automatic settle();
    wait (pending_reqs.size() == 0 && awaited.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Times cluster on a small pool so that begins tie and windows overlap.
  function automatic longint pool_time();
    int r;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: return (r < 50) ? T_MIN : T_MIN + 3;
      1: return (r < 50) ? T_MAX : T_MAX - 3;
      default: return longint'($urandom_range(8)) * 50 - 200;
    endcase
  endfunction

  function automatic longint pick_begin();
    return ($urandom_range(9) == 0) ? pool_time() : longint'($urandom_range(8)) * 50 - 200;
  endfunction

  function automatic logic [31:0] pick_tol();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(60);
    endcase
  endfunction

  function automatic in_t good_write(int s);
    in_t q;
    q                = '0;
    q.end_time       = rand64();
    q.current_time   = rand64();
    q.kind           = KIND_WRITE;
    q.slot           = 6'(s);
    q.key_id         = home_id[s];
    q.entry_enabled  = ($urandom_range(9) != 0);
    q.secret_nonzero = 1'b1;
    q.secret_set     = 1'b1;
    q.algorithm_set  = 1'b1;
    q.begin_time     = pick_begin();
    q.has_end        = $urandom_range(1) && q.begin_time < T_MAX - 1000;
    if (q.has_end) q.end_time = q.begin_time + $urandom_range(1, 500);
    q.tolerance      = pick_tol();
    return q;
  endfunction

  function automatic in_t query(kind_t k, int n);
    in_t q;
    q              = '0;
    q.kind         = k;
    q.key_id       = ($urandom_range(9) == 0 || n == 0) ? 8'($urandom)
                                                        : home_id[$urandom_range(n - 1)];
    q.tolerance    = $urandom;
    q.current_time = ($urandom_range(5) == 0) ? pool_time()
                     : longint'($urandom_range(8)) * 50 - 200 + $urandom_range(40) - 20;
    return q;
  endfunction

  // Random mix: mostly well-formed writes and queries, some raw noise.
  task automatic random_traffic(int count);
    int n;
    int s;
    int r;
    in_t q;
    logic [255:0] raw;
    n = used_slots();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        raw = {rand64(), rand64(), rand64(), rand64()};
        q   = raw[$bits(in_t)-1:0];
        bad_slot[q.slot] = 1;
        pending_reqs.push_back(q);
      end else if (r < 35) begin
        s = $urandom_range(MAX_ENTRIES - 1);
        if (n > 0 && $urandom_range(3) != 0) s = $urandom_range(n - 1);
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (bad_slot[i] && $urandom_range(1)) s = i;
        bad_slot[s] = 0;
        pending_reqs.push_back(good_write(s));
      end else begin
        pending_reqs.push_back(query(r < 68 ? KIND_SEND : KIND_RECV, n));
      end
    end
  endtask

  // Faults one at a time, each repaired before the next.
  task automatic directed_set();
    in_t q;
    pending_reqs.push_back(query(KIND_SEND, 0));
    q = query(KIND_RECV, 0);
    q.key_id = 8'hFF;
    pending_reqs.push_back(q);
    q = query(KIND_SEND, 0);
    q.kind = KIND_NONE;
    pending_reqs.push_back(q);
    q = query(KIND_SEND, 0);
    q.current_time = T_MAX;
    pending_reqs.push_back(q);
    q.current_time = T_MIN;
    pending_reqs.push_back(q);
    q = good_write(1);
    q.key_id = 8'd200;
    pending_reqs.push_back(q);
    pending_reqs.push_back(good_write(1));
    q = good_write(2);
    q.secret_nonzero = 1'b0;
    pending_reqs.push_back(q);
    q.secret_set = 1'b0;
    pending_reqs.push_back(q);
    q = good_write(2);
    q.algorithm_set = 1'b0;
    pending_reqs.push_back(q);
    q = good_write(2);
    q.has_end  = 1'b1;
    q.end_time = q.begin_time;
    pending_reqs.push_back(q);
    q = good_write(2);
    q.key_id = home_id[0];
    pending_reqs.push_back(q);
    pending_reqs.push_back(good_write(2));
    q = good_write(0);
    q.begin_time = T_MAX;
    q.tolerance  = 32'hFFFF_FFFF;
    q.has_end    = 1'b0;
    pending_reqs.push_back(q);
    q = query(KIND_RECV, 0);
    q.key_id       = home_id[0];
    q.current_time = T_MAX - 5;
    pending_reqs.push_back(q);
    q = good_write(0);
    q.begin_time = T_MIN;
    pending_reqs.push_back(q);
    q = query(KIND_RECV, 0);
    q.key_id       = home_id[0];
    q.current_time = T_MIN;
    pending_reqs.push_back(q);
    pending_reqs.push_back(good_write(0));
  endtask

  // Register settings per phase, extremes included.
  logic [7:0] ph_en   [10] = '{1, 1, 0, 1, 1, 1, 1, 1, 1, 1};
  logic [7:0] ph_cnt  [10] = '{8, 64, 8, 0, 100, 127, 3, 3, 64, 16};
  logic [7:0] ph_name [10] = '{5, 32, 1, 10, 20, 32, 0, 33, 255, 7};

  initial begin
    errors    = 0;
    took      = 0;
    quiet     = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data  = '0;
    chain_en   = 0;
    slots_used = 0;
    name_len   = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      home_id[i]  = 8'((i * 37) % 64);
      bad_slot[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every slot while no slot is in use, so no unwritten entry is read.
    for (int i = 0; i < MAX_ENTRIES; i++) pending_reqs.push_back(good_write(i));
    settle();

    for (int p = 0; p < 10; p++) begin
      reg_write(CFG_ENABLE, ph_en[p]);
      reg_write(CFG_COUNT, ph_cnt[p]);
      reg_write(CFG_NAME, ph_name[p]);
      @(negedge clk);
      cfg_valid <= 1'b0;
      quiet = (p == 4);
      if (p == 0) directed_set();
      random_traffic(80);
      settle();
    end

    if (errors == 0) begin
      $display("auth_key_rollover_select verification clean");
    end else begin
      $display("auth_key_rollover_select verification failed");
    end
    $finish;
  end

endmodule
